>>> design/cfpr_pkg.sv
// Package: shared types, codes and the CRC byte update for the framed packet receiver.
`default_nettype none
package cfpr_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  // Event codes on the output channel
  localparam logic [1:0] EVT_START   = 2'd0;
  localparam logic [1:0] EVT_PAYLOAD = 2'd1;
  localparam logic [1:0] EVT_END     = 2'd2;

  // Configuration register indexes
  localparam logic REG_RETRY_WINDOW = 1'b0;

  localparam int unsigned ADDR_W = 3;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;
  localparam logic [15:0] RETRY_RESET    = 16'd500;
  localparam logic [6:0]  LEN_MASK       = 7'h7F;

  typedef enum logic [2:0] {
    PH_ADDR = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAY  = 3'd2,
    PH_CLO  = 3'd3,
    PH_CHI  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] frame_address;
    logic       toggle_bit;
    logic [6:0] payload_length;
    logic [6:0] payload_index;
    logic [7:0] payload_value;
    logic       crc_ok;
    logic       is_retry;
  } event_t;

  // Reflected CCITT update over one byte, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/cfpr_if.sv
// Interfaces: request channel and event channel of the framed packet receiver.
`default_nettype none
interface cfpr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface cfpr_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] frame_address;
  logic       toggle_bit;
  logic [6:0] payload_length;
  logic [6:0] payload_index;
  logic [7:0] payload_value;
  logic       crc_ok;
  logic       is_retry;

  modport source (output valid, output event_kind, output frame_address, output toggle_bit,
                  output payload_length, output payload_index, output payload_value,
                  output crc_ok, output is_retry, input ready);
  modport sink   (input valid, input event_kind, input frame_address, input toggle_bit,
                  input payload_length, input payload_index, input payload_value,
                  input crc_ok, input is_retry, output ready);
endinterface
`default_nettype wire

>>> design/crc_framed_packet_receiver.sv
// Top level: framed packet receiver with CRC-16/X.25 check and retry detection.
//
//   channel  dir  handshake            carries
//   req      in   valid/ready          req_type, data_byte
//   evt      out  valid/ready          event_kind, address, length, payload, crc flags
//   apb      in   psel/penable/pready  retry window at byte address 0
//
// One request is taken per cycle while req.ready is high; the parser state and the
// byte-wide CRC update settle within that cycle, and any event lands in the output
// register, or in the skid entry on stall. A two-entry output (register plus skid)
// keeps req ready while one event waits; req.ready drops only while both output
// entries are full. rst is synchronous: parser returns to the address phase, CRC to
// 0xFFFF, retry window to 500.
`default_nettype none
module crc_framed_packet_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  cfpr_req_if.sink                           req,
  cfpr_evt_if.source                         evt,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cfpr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import cfpr_pkg::*;

  // Configuration
  logic [15:0] retry_window;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  held_address, held_address_next;
  logic [6:0]  held_length, held_length_next;
  logic [6:0]  byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic [15:0] last_valid_crc, last_valid_crc_next;
  logic [15:0] ticks_since_valid, ticks_since_valid_next;

  // Output register and skid entry
  event_t      obuf, skid, res;
  logic        obuf_valid, skid_valid;
  logic        has_res;

  logic        req_fire;
  logic        out_free;
  logic [15:0] crc_upd;
  logic [15:0] rcv_crc;
  logic [6:0]  pos_inc;

  // APB register access
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_RETRY_WINDOW) ? {16'h0000, retry_window} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_window <= RETRY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1] == REG_RETRY_WINDOW) begin
      retry_window <= pwdata[15:0];
    end
  end

  assign req.ready = !skid_valid;
  assign req_fire  = req.valid && req.ready;
  assign crc_upd   = crc_byte(running_crc, req.data_byte);
  assign rcv_crc   = {req.data_byte, received_crc_low};
  assign pos_inc   = byte_position + 7'd1;

  // Parse one request and form its event
  always_comb begin
    phase_next             = phase;
    held_address_next      = held_address;
    held_length_next       = held_length;
    byte_position_next     = byte_position;
    running_crc_next       = running_crc;
    received_crc_low_next  = received_crc_low;
    last_valid_crc_next    = last_valid_crc;
    ticks_since_valid_next = ticks_since_valid;
    has_res                = 1'b0;
    res                    = '0;
    if (req_fire) begin
      unique case (req.req_type)
        REQ_TIMEOUT: begin
          phase_next       = PH_ADDR;
          running_crc_next = CRC_INIT;
        end
        REQ_TICK: begin
          if (ticks_since_valid != TICK_MAX) begin
            ticks_since_valid_next = ticks_since_valid + 16'd1;
          end
        end
        REQ_BYTE: begin
          unique case (phase)
            PH_ADDR: begin
              running_crc_next  = crc_upd;
              held_address_next = req.data_byte;
              phase_next        = PH_LEN;
            end
            PH_LEN: begin
              held_length_next   = req.data_byte[6:0] & LEN_MASK;
              has_res            = 1'b1;
              res.event_kind     = EVT_START;
              res.frame_address  = held_address;
              res.toggle_bit     = req.data_byte[7];
              res.payload_length = req.data_byte[6:0];
              if (req.data_byte[6:0] != 7'd0) begin
                running_crc_next   = crc_upd;
                byte_position_next = 7'd0;
                phase_next         = PH_PAY;
              end else begin
                running_crc_next = crc_upd ^ CRC_INIT;
                phase_next       = PH_CLO;
              end
            end
            PH_PAY: begin
              has_res            = 1'b1;
              res.event_kind     = EVT_PAYLOAD;
              res.payload_index  = byte_position;
              res.payload_value  = req.data_byte;
              byte_position_next = pos_inc;
              if (pos_inc == held_length) begin
                running_crc_next = crc_upd ^ CRC_INIT;
                phase_next       = PH_CLO;
              end else begin
                running_crc_next = crc_upd;
              end
            end
            PH_CLO: begin
              received_crc_low_next = req.data_byte;
              phase_next            = PH_CHI;
            end
            PH_CHI: begin
              has_res        = 1'b1;
              res.event_kind = EVT_END;
              res.crc_ok     = (rcv_crc == running_crc);
              res.is_retry   = (rcv_crc == last_valid_crc) &&
                               (ticks_since_valid <= retry_window);
              if (rcv_crc == running_crc) begin
                last_valid_crc_next    = rcv_crc;
                ticks_since_valid_next = 16'd0;
              end
              phase_next       = PH_ADDR;
              running_crc_next = CRC_INIT;
            end
            default: begin
              phase_next       = PH_ADDR;
              running_crc_next = CRC_INIT;
            end
          endcase
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_ADDR;
      held_address      <= 8'd0;
      held_length       <= 7'd0;
      byte_position     <= 7'd0;
      running_crc       <= CRC_INIT;
      received_crc_low  <= 8'd0;
      last_valid_crc    <= 16'd0;
      ticks_since_valid <= 16'd0;
    end else begin
      phase             <= phase_next;
      held_address      <= held_address_next;
      held_length       <= held_length_next;
      byte_position     <= byte_position_next;
      running_crc       <= running_crc_next;
      received_crc_low  <= received_crc_low_next;
      last_valid_crc    <= last_valid_crc_next;
      ticks_since_valid <= ticks_since_valid_next;
    end
  end

  // Advance the output register, park a new event in the skid entry on stall
  assign out_free = !obuf_valid || evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        obuf_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        obuf_valid <= has_res;
      end
    end else if (has_res) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      obuf <= skid_valid ? skid : res;
    end else if (has_res) begin
      skid <= res;
    end
  end

  assign evt.valid          = obuf_valid;
  assign evt.event_kind     = obuf.event_kind;
  assign evt.frame_address  = obuf.frame_address;
  assign evt.toggle_bit     = obuf.toggle_bit;
  assign evt.payload_length = obuf.payload_length;
  assign evt.payload_index  = obuf.payload_index;
  assign evt.payload_value  = obuf.payload_value;
  assign evt.crc_ok         = obuf.crc_ok;
  assign evt.is_retry       = obuf.is_retry;

  // Skid entry only fills behind a full output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> obuf_valid)
    else $error("skid entry valid while output register empty");

  // Payload position stays below the frame length
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (byte_position < held_length) && (held_length != 7'd0))
    else $error("payload position outside frame");

  // A timeout restarts the parser
  assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.req_type == REQ_TIMEOUT) |=>
      (phase == PH_ADDR) && (running_crc == CRC_INIT))
    else $error("timeout did not restart parser");

  // Tick counter only rises, saturates, or clears on a good frame
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (ticks_since_valid >= $past(ticks_since_valid)) ||
                    (ticks_since_valid == 16'd0))
    else $error("tick counter moved backwards");

endmodule
`default_nettype wire
